### sv/bpc_pkg.sv
// shared types and constants for the button press classifier
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd2;
  localparam logic [CNT_W-1:0] LONG_RST     = 8'd100;
  localparam logic [CNT_W-1:0] WINDOW_RST   = 8'd30;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ON     = 4'b0010,
    PH_WAIT   = 4'b0100,
    PH_DOUBLE = 4'b1000
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] double_window_ticks;
  } cls_cfg_t;

endpackage

### sv/bpc_debounce.sv
// debouncer: stable level and hold counter
`timescale 1ns / 1ps

module bpc_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic                      raw_level,
  input  logic [bpc_pkg::CNT_W-1:0] debounce_ticks,
  output logic                      stable_nxt
);

  logic                      stable_r;
  logic [bpc_pkg::CNT_W-1:0] count_r;
  logic [bpc_pkg::CNT_W-1:0] count_nxt;

  always_comb begin
    stable_nxt = stable_r;
    count_nxt  = count_r;
    if (count_r <= debounce_ticks) begin
      count_nxt = count_r + 8'd1;
    end else if (stable_r != raw_level) begin
      stable_nxt = raw_level;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      count_r  <= '0;
    end else if (step_en) begin
      stable_r <= stable_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### sv/bpc_classifier.sv
// press classifier: phase, judge counter and held event
`timescale 1ns / 1ps

module bpc_classifier (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              level_on,
  input  bpc_pkg::cls_cfg_t cfg,
  output bpc_pkg::event_t   event_nxt
);

  bpc_pkg::phase_t           phase_r;
  bpc_pkg::phase_t           phase_nxt;
  logic [bpc_pkg::CNT_W-1:0] judge_r;
  logic [bpc_pkg::CNT_W-1:0] judge_nxt;
  logic [bpc_pkg::CNT_W-1:0] judge_inc;
  bpc_pkg::event_t           event_r;

  assign judge_inc = judge_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    judge_nxt = judge_r;
    event_nxt = event_r;
    case (phase_r)
      bpc_pkg::PH_IDLE: begin
        if (level_on) begin
          phase_nxt = bpc_pkg::PH_ON;
        end
        event_nxt = bpc_pkg::EV_NONE;
        judge_nxt = '0;
      end
      bpc_pkg::PH_ON: begin
        if (level_on) begin
          if (judge_r < cfg.long_press_ticks) begin
            judge_nxt = judge_inc;
            if (judge_inc == cfg.long_press_ticks) begin
              event_nxt = bpc_pkg::EV_LONG;
            end
          end else begin
            event_nxt = bpc_pkg::EV_NONE;
          end
        end else if (judge_r >= cfg.long_press_ticks) begin
          phase_nxt = bpc_pkg::PH_IDLE;
          event_nxt = bpc_pkg::EV_NONE;
        end else begin
          phase_nxt = bpc_pkg::PH_WAIT;
          judge_nxt = '0;
        end
      end
      bpc_pkg::PH_WAIT: begin
        if (!level_on) begin
          if (judge_r <= cfg.double_window_ticks) begin
            judge_nxt = judge_inc;
          end else begin
            phase_nxt = bpc_pkg::PH_IDLE;
            event_nxt = bpc_pkg::EV_SHORT;
          end
        end else begin
          phase_nxt = bpc_pkg::PH_DOUBLE;
          event_nxt = bpc_pkg::EV_DOUBLE;
          judge_nxt = '0;
        end
      end
      bpc_pkg::PH_DOUBLE: begin
        event_nxt = bpc_pkg::EV_NONE;
        if (!level_on) begin
          phase_nxt = bpc_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = bpc_pkg::PH_IDLE;
        judge_nxt = '0;
        event_nxt = bpc_pkg::EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpc_pkg::PH_IDLE;
      judge_r <= '0;
      event_r <= bpc_pkg::EV_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      judge_r <= judge_nxt;
      event_r <= event_nxt;
    end
  end

endmodule

### sv/button_press_classifier.sv
// button press classifier top level: input register, debouncer, classifier, result register
// an accepted item passes the input register, then the result register, to the output
// one item per cycle unless the output stalls; input and result registers part the sides
// every item runs the debouncer and the classifier in one pass on the previous item's state
// reset (synchronous, rst_n low): state cleared, phase idle, registers back to 2, 100 and 30
`timescale 1ns / 1ps

module button_press_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] raw_level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [1:0] press_event
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CNT_W-1:0]         cfg_data
);

  logic                      s1_valid_r;
  logic                      s1_level_r;
  logic                      out_valid_r;
  bpc_pkg::event_t           out_event_r;
  logic                      out_free;
  logic                      step_en;
  logic                      stable_nxt;
  bpc_pkg::event_t           event_nxt;
  logic [bpc_pkg::CNT_W-1:0] debounce_ticks_r;
  bpc_pkg::cls_cfg_t         cls_cfg_r;

  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_event_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r              <= bpc_pkg::DEBOUNCE_RST;
      cls_cfg_r.long_press_ticks    <= bpc_pkg::LONG_RST;
      cls_cfg_r.double_window_ticks <= bpc_pkg::WINDOW_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bpc_pkg::REG_DEBOUNCE) begin
        debounce_ticks_r <= cfg_data;
      end else if (cfg_index == bpc_pkg::REG_LONG) begin
        cls_cfg_r.long_press_ticks <= cfg_data;
      end else if (cfg_index == bpc_pkg::REG_WINDOW) begin
        cls_cfg_r.double_window_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_event_r <= event_nxt;
    end
  end

  bpc_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .raw_level      (s1_level_r),
    .debounce_ticks (debounce_ticks_r),
    .stable_nxt     (stable_nxt)
  );

  bpc_classifier u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .level_on  (stable_nxt),
    .cfg       (cls_cfg_r),
    .event_nxt (event_nxt)
  );

endmodule

### sv/bpc_checker.sv
// port-level checker for the button press classifier, bound to the top level
`timescale 1ns / 1ps

module bpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // input stalls only behind a stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output free");

  // an accepted item passes both registers to the output or waits behind a pending result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted item lost");

  // padding bits stay zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("nonzero padding in result item");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/tb_top.sv
// testbench for the button press classifier: tick stimulus, event prediction and checking
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_TICKS = 300;

  typedef logic [bpc_pkg::CNT_W-1:0] lim_t;

  class press_scoreboard;
    lim_t              debounce_lim;
    lim_t              long_lim;
    lim_t              window_lim;
    logic              level;
    lim_t              bounce_cnt;
    lim_t              judge_cnt;
    bpc_pkg::phase_t   phase;
    bpc_pkg::event_t   held_ev;
    bpc_pkg::event_t   expected_events[$];
    int unsigned       fails;

    function new();
      debounce_lim = bpc_pkg::DEBOUNCE_RST;
      long_lim     = bpc_pkg::LONG_RST;
      window_lim   = bpc_pkg::WINDOW_RST;
      level        = 1'b0;
      bounce_cnt   = '0;
      judge_cnt    = '0;
      phase        = bpc_pkg::PH_IDLE;
      held_ev      = bpc_pkg::EV_NONE;
      fails        = 0;
    endfunction

    function void set_reg(bpc_pkg::reg_idx_t idx, lim_t value);
      case (idx)
        bpc_pkg::REG_DEBOUNCE: debounce_lim = value;
        bpc_pkg::REG_LONG:     long_lim = value;
        bpc_pkg::REG_WINDOW:   window_lim = value;
        default: ;
      endcase
    endfunction

    // one tick: debounce the raw level, then advance the press classifier
    function void note_tick(logic raw);
      if (bounce_cnt <= debounce_lim) begin
        bounce_cnt = bounce_cnt + 1'b1;
      end else if (level != raw) begin
        level = raw;
        bounce_cnt = '0;
      end
      case (phase)
        bpc_pkg::PH_IDLE: begin
          if (level) phase = bpc_pkg::PH_ON;
          held_ev = bpc_pkg::EV_NONE;
          judge_cnt = '0;
        end
        bpc_pkg::PH_ON: begin
          if (level) begin
            if (judge_cnt < long_lim) begin
              judge_cnt = judge_cnt + 1'b1;
              if (judge_cnt == long_lim) held_ev = bpc_pkg::EV_LONG;
            end else begin
              held_ev = bpc_pkg::EV_NONE;
            end
          end else if (judge_cnt >= long_lim) begin
            phase = bpc_pkg::PH_IDLE;
            held_ev = bpc_pkg::EV_NONE;
          end else begin
            phase = bpc_pkg::PH_WAIT;
            judge_cnt = '0;
          end
        end
        bpc_pkg::PH_WAIT: begin
          if (!level) begin
            if (judge_cnt <= window_lim) begin
              judge_cnt = judge_cnt + 1'b1;
            end else begin
              phase = bpc_pkg::PH_IDLE;
              held_ev = bpc_pkg::EV_SHORT;
            end
          end else begin
            phase = bpc_pkg::PH_DOUBLE;
            held_ev = bpc_pkg::EV_DOUBLE;
            judge_cnt = '0;
          end
        end
        default: begin
          held_ev = bpc_pkg::EV_NONE;
          if (!level) phase = bpc_pkg::PH_IDLE;
        end
      endcase
      expected_events.push_back(held_ev);
    endfunction

    function void check_event(logic [7:0] data);
      bpc_pkg::event_t want;
      if (expected_events.size() == 0) begin
        $error("press_event with no item pending: actual %0d", data[1:0]);
        fails++;
        return;
      end
      want = expected_events.pop_front();
      if (data[1:0] !== want) begin
        $error("press_event mismatch: expected %0d, actual %0d", want, data[1:0]);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;    // [0] raw_level
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;        // [1:0] press_event
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  bpc_pkg::reg_idx_t cfg_index = bpc_pkg::REG_DEBOUNCE;
  lim_t              cfg_data = '0;

  press_scoreboard sb;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  long_hold_req = 1'b0;

  button_press_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_tick(in_tdata[0]);
    if (rst_n && out_tvalid && out_tready) sb.check_event(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("button_press_classifier verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    int          hold_left;
    int          mode;
    int          mode_left;
    int unsigned beat;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      beat++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 80;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((beat % 5) != 2);
        endcase
      end
    end
  end

  task automatic send_tick(input logic raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_run(input logic raw, input int count);
    repeat (count) send_tick(raw);
  endtask

  // first let the last accepted item reach the queue, then wait for the queue to drain
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bpc_pkg::reg_idx_t idx, input lim_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input lim_t deb, input lim_t lng, input lim_t win);
    wait_drained();
    write_reg(bpc_pkg::REG_DEBOUNCE, deb);
    write_reg(bpc_pkg::REG_LONG, lng);
    write_reg(bpc_pkg::REG_WINDOW, win);
    cfg_valid <= 1'b0;
  endtask

  // alternating press and release runs around the current limits, with some glitches
  task automatic run_presses(input int count);
    logic raw;
    int   len;
    int   deb;
    int   lim;
    raw = ~sb.level;
    while (count > 0) begin
      deb = int'(sb.debounce_lim);
      lim = raw ? int'(sb.long_lim) : int'(sb.window_lim);
      if ($urandom_range(0, 9) < 2) len = $urandom_range(1, deb + 1);
      else len = deb + 2 + $urandom_range(0, lim + 6);
      if (len > count) len = count;
      send_run(raw, len);
      count -= len;
      raw = ~raw;
    end
  endtask

  initial begin
    int   random_ticks;
    int   count;
    lim_t deb;
    lim_t lng;
    lim_t win;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short, double, long and held-past-long presses
    configure(8'd0, 8'd3, 8'd2);
    send_run(1'b1, 2);
    send_run(1'b0, 6);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 3);
    send_run(1'b0, 2);
    send_run(1'b1, 6);
    send_run(1'b0, 2);

    // long limit of zero
    configure(8'd1, 8'd0, 8'd3);
    send_run(1'b1, 6);
    send_run(1'b0, 10);
    send_run(1'b1, 6);
    send_run(1'b0, 10);

    // window of 255 wraps and never expires
    configure(8'd0, 8'd20, 8'd255);
    send_run(1'b1, 4);
    send_run(1'b0, 270);
    send_run(1'b1, 6);
    send_run(1'b0, 8);

    // debounce 255 never accepts
    configure(8'd255, 8'd1, 8'd0);
    send_run(1'b1, 264);

    // random part, first at the reset limits with a long output hold-off
    configure(bpc_pkg::DEBOUNCE_RST, bpc_pkg::LONG_RST, bpc_pkg::WINDOW_RST);
    long_hold_req = 1'b1;
    run_presses(200);
    random_ticks = 200;
    while (random_ticks < RANDOM_TICKS) begin
      deb = lim_t'($urandom_range(0, 4));
      lng = lim_t'($urandom_range(1, 16));
      win = lim_t'($urandom_range(0, 12));
      if ($urandom_range(0, 5) == 0) deb = lim_t'($urandom_range(0, 20));
      if ($urandom_range(0, 5) == 0) lng = lim_t'($urandom_range(1, 60));
      configure(deb, lng, win);
      count = $urandom_range(60, 140);
      if ($urandom_range(0, 3) == 0) long_hold_req = 1'b1;
      run_presses(count);
      random_ticks += count;
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.fails == 0 && sb.expected_events.size() == 0) begin
      $display("button_press_classifier verification clean");
    end else begin
      $display("button_press_classifier verification failed");
    end
    $finish;
  end

endmodule
